[rtl/core/slcp_pkg.sv]
`timescale 1ns / 1ps

package slcp_pkg;

    localparam int LINE_LEN = 48;
    localparam int NAME_LEN = 32;
    localparam int WIFI_LEN = 32;
    localparam int ADDR_LEN = 16;

    localparam int STORE_DEPTH = LINE_LEN - 1;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(LINE_LEN);
    localparam int POS_W       = $clog2(LINE_LEN + 72);

    localparam int NAME_AW = $clog2(NAME_LEN);
    localparam int WIFI_AW = $clog2(WIFI_LEN);
    localparam int ADDR_AW = $clog2(ADDR_LEN);

    localparam int MAX_TEXT = (NAME_LEN > WIFI_LEN) ?
                              ((NAME_LEN > ADDR_LEN) ? NAME_LEN : ADDR_LEN) :
                              ((WIFI_LEN > ADDR_LEN) ? WIFI_LEN : ADDR_LEN);
    localparam int CNT_W   = $clog2(MAX_TEXT);
    localparam int IDX_W   = 7;

    localparam int START_NAME = 6;
    localparam int START_WIFI = 6;
    localparam int START_IP   = 4;
    localparam int START_BLE  = 5;
    localparam int MATCH_LAST = 5;

    localparam logic [47:0] PFX_NAME = "#NAME ";
    localparam logic [47:0] PFX_WIFI = "#WIFI ";
    localparam logic [31:0] PFX_IP   = "#IP ";
    localparam logic [39:0] PFX_BLE  = "#BLE ";

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic [1:0] SEL_NAME = 2'd0;
    localparam logic [1:0] SEL_WIFI = 2'd1;
    localparam logic [1:0] SEL_ADDR = 2'd2;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_COPY,
        S_BLE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_NAME = 3'd1,
        KIND_WIFI = 3'd2,
        KIND_IP   = 3'd3,
        KIND_BLE  = 3'd4
    } t_kind;

    function automatic logic [7:0] prefix_char(input t_kind kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (kind)
            KIND_NAME: begin
                if (pos < 3'd6) ch = PFX_NAME[8*(5-int'(pos)) +: 8];
            end
            KIND_WIFI: begin
                if (pos < 3'd6) ch = PFX_WIFI[8*(5-int'(pos)) +: 8];
            end
            KIND_IP: begin
                if (pos < 3'd4) ch = PFX_IP[8*(3-int'(pos)) +: 8];
            end
            KIND_BLE: begin
                if (pos < 3'd5) ch = PFX_BLE[8*(4-int'(pos)) +: 8];
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/slcp_ram.sv]
`timescale 1ns / 1ps

module slcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 47
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/status_line_command_parser.sv]
`timescale 1ns / 1ps
// Channel    Direction  Handshake                  Payload
// request    in         i_in_valid / o_in_ready    i_opcode, i_rx_byte, i_text_select,
//                                                  i_char_index, i_now_ms
// result     out        o_out_valid / i_out_ready  o_line_applied, o_command_kind,
//                                                  o_line_discarded, o_text_char,
//                                                  o_ble_level, o_link_seen, o_link_active
// config     in         psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A read or a stored byte passes through the final state; a line end runs a sequencer over the line
// buffer memory, one character per cycle through its single read port.
// A line end first matches the 6-character prefix, then copies up to 32 characters or
// scans up to 43 characters for the BLE level.
// Reset is synchronous and active low; it clears the texts and flags at once.
// The next request is taken while the previous result still waits in the output
// register; a result waits in the final state while the output is stalled.

module status_line_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_rx_byte,
    input  logic [1:0]  i_text_select,
    input  logic [4:0]  i_char_index,
    input  logic [31:0] i_now_ms,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_line_applied,
    output logic [2:0]  o_command_kind,
    output logic        o_line_discarded,
    output logic [7:0]  o_text_char,
    output logic [7:0]  o_ble_level,
    output logic        o_link_seen,
    output logic        o_link_active,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    slcp_pkg::t_state r_state, n_state;
    slcp_pkg::t_kind  r_kind, n_kind;

    logic [slcp_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [slcp_pkg::POS_W-1:0]  r_qpos, rd_pos;
    logic [slcp_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic                        r_ended, n_ended;
    logic r_m_name, n_m_name, r_m_wifi, n_m_wifi, r_m_ip, n_m_ip, r_m_ble, n_m_ble;
    logic                        r_neg, n_neg, r_bdig, n_bdig;
    logic [7:0]                  r_acc, n_acc;
    logic [7:0]                  r_ble, n_ble;
    logic                        r_seen, n_seen;
    logic [31:0]                 r_last, n_last;
    logic [31:0]                 r_now, n_now;
    logic [31:0]                 r_timeout;
    logic                        r_disc, n_disc;
    logic [7:0]                  r_tc, n_tc;

    logic [7:0] r_name [slcp_pkg::NAME_LEN];
    logic [7:0] n_name [slcp_pkg::NAME_LEN];
    logic [7:0] r_wifi [slcp_pkg::WIFI_LEN];
    logic [7:0] n_wifi [slcp_pkg::WIFI_LEN];
    logic [7:0] r_addr [slcp_pkg::ADDR_LEN];
    logic [7:0] n_addr [slcp_pkg::ADDR_LEN];

    logic        r_ov, n_ov;
    logic        r_o_applied, n_o_applied;
    logic [2:0]  r_o_kind, n_o_kind;
    logic        r_o_disc, n_o_disc;
    logic [7:0]  r_o_tc, n_o_tc;
    logic [7:0]  r_o_ble, n_o_ble;
    logic        r_o_seen, n_o_seen;
    logic        r_o_active, n_o_active;

    logic        accept;
    logic        is_term;
    logic        ram_we;
    logic [7:0]  ram_q;
    logic [7:0]  c;
    logic [2:0]  qi;
    logic        m_name, m_wifi, m_ip, m_ble;
    logic        is_ws, is_dig;
    logic [7:0]  digit, acc10;
    logic [7:0]  wr_char;
    logic [slcp_pkg::CNT_W-1:0] lim;
    logic [slcp_pkg::IDX_W-1:0] idx_ext;
    logic [31:0] elapsed;
    logic        cfg_write;

    slcp_ram #(
        .WIDTH (8),
        .DEPTH (slcp_pkg::STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[slcp_pkg::STORE_AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (rd_pos[slcp_pkg::STORE_AW-1:0]),
        .o_rdata (ram_q)
    );

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == slcp_pkg::REG_TIMEOUT) ? r_timeout : 32'd0;

    assign accept  = i_in_valid && (r_state == slcp_pkg::S_IDLE);
    assign is_term = (i_rx_byte == slcp_pkg::CH_LF) || (i_rx_byte == slcp_pkg::CH_CR);
    assign c       = (r_qpos < slcp_pkg::POS_W'(r_fill)) ? ram_q : 8'h00;
    assign qi      = r_qpos[2:0];
    assign idx_ext = {2'b00, i_char_index};
    assign is_ws   = (c == slcp_pkg::CH_SPACE) || (c == slcp_pkg::CH_TAB) ||
                     (c == slcp_pkg::CH_VT) || (c == slcp_pkg::CH_FF);
    assign is_dig  = (c >= slcp_pkg::CH_ZERO) && (c <= slcp_pkg::CH_NINE);
    assign digit   = c - slcp_pkg::CH_ZERO;
    assign acc10   = {r_acc[4:0], 3'b000} + {r_acc[6:0], 1'b0};
    assign elapsed = r_now - r_last;

    assign m_name = r_m_name && (c == slcp_pkg::prefix_char(slcp_pkg::KIND_NAME, qi));
    assign m_wifi = r_m_wifi && (c == slcp_pkg::prefix_char(slcp_pkg::KIND_WIFI, qi));
    assign m_ip   = r_m_ip && ((r_qpos >= slcp_pkg::POS_W'(slcp_pkg::START_IP)) ||
                    (c == slcp_pkg::prefix_char(slcp_pkg::KIND_IP, qi)));
    assign m_ble  = r_m_ble && ((r_qpos >= slcp_pkg::POS_W'(slcp_pkg::START_BLE)) ||
                    (c == slcp_pkg::prefix_char(slcp_pkg::KIND_BLE, qi)));

    always_comb begin
        unique case (r_kind)
            slcp_pkg::KIND_NAME: lim = slcp_pkg::CNT_W'(slcp_pkg::NAME_LEN - 1);
            slcp_pkg::KIND_WIFI: lim = slcp_pkg::CNT_W'(slcp_pkg::WIFI_LEN - 1);
            slcp_pkg::KIND_IP:   lim = slcp_pkg::CNT_W'(slcp_pkg::ADDR_LEN - 1);
            default:             lim = '0;
        endcase
        wr_char = (!r_ended && (r_idx != lim)) ? c : 8'h00;
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_ended  = r_ended;
        n_m_name = r_m_name;
        n_m_wifi = r_m_wifi;
        n_m_ip   = r_m_ip;
        n_m_ble  = r_m_ble;
        n_neg    = r_neg;
        n_bdig   = r_bdig;
        n_acc    = r_acc;
        n_ble    = r_ble;
        n_seen   = r_seen;
        n_last   = r_last;
        n_now    = r_now;
        n_disc   = r_disc;
        n_tc     = r_tc;
        n_name   = r_name;
        n_wifi   = r_wifi;
        n_addr   = r_addr;
        rd_pos   = r_qpos + 1'b1;
        ram_we   = 1'b0;

        n_ov        = r_ov && !i_out_ready;
        n_o_applied = r_o_applied;
        n_o_kind    = r_o_kind;
        n_o_disc    = r_o_disc;
        n_o_tc      = r_o_tc;
        n_o_ble     = r_o_ble;
        n_o_seen    = r_o_seen;
        n_o_active  = r_o_active;

        unique case (r_state)
            slcp_pkg::S_IDLE: begin
                rd_pos = '0;
                if (accept) begin
                    n_now  = i_now_ms;
                    n_kind = slcp_pkg::KIND_NONE;
                    n_disc = 1'b0;
                    n_tc   = 8'h00;
                    if (i_opcode == slcp_pkg::OP_READ) begin
                        unique case (i_text_select)
                            slcp_pkg::SEL_NAME: begin
                                if (idx_ext < slcp_pkg::IDX_W'(slcp_pkg::NAME_LEN))
                                    n_tc = r_name[idx_ext[slcp_pkg::NAME_AW-1:0]];
                            end
                            slcp_pkg::SEL_WIFI: begin
                                if (idx_ext < slcp_pkg::IDX_W'(slcp_pkg::WIFI_LEN))
                                    n_tc = r_wifi[idx_ext[slcp_pkg::WIFI_AW-1:0]];
                            end
                            slcp_pkg::SEL_ADDR: begin
                                if (idx_ext < slcp_pkg::IDX_W'(slcp_pkg::ADDR_LEN))
                                    n_tc = r_addr[idx_ext[slcp_pkg::ADDR_AW-1:0]];
                            end
                            default: n_tc = 8'h00;
                        endcase
                        n_state = slcp_pkg::S_DONE;
                    end else if (is_term) begin
                        if (r_fill != '0) begin
                            n_m_name = 1'b1;
                            n_m_wifi = 1'b1;
                            n_m_ip   = 1'b1;
                            n_m_ble  = 1'b1;
                            n_state  = slcp_pkg::S_MATCH;
                        end else begin
                            n_state = slcp_pkg::S_DONE;
                        end
                    end else if (r_fill < slcp_pkg::FILL_W'(slcp_pkg::STORE_DEPTH)) begin
                        ram_we  = 1'b1;
                        n_fill  = r_fill + 1'b1;
                        n_state = slcp_pkg::S_DONE;
                    end else begin
                        n_fill  = '0;
                        n_disc  = 1'b1;
                        n_state = slcp_pkg::S_DONE;
                    end
                end
            end

            slcp_pkg::S_MATCH: begin
                n_m_name = m_name;
                n_m_wifi = m_wifi;
                n_m_ip   = m_ip;
                n_m_ble  = m_ble;
                if (r_qpos == slcp_pkg::POS_W'(slcp_pkg::MATCH_LAST)) begin
                    n_idx   = '0;
                    n_ended = 1'b0;
                    n_neg   = 1'b0;
                    n_bdig  = 1'b0;
                    n_acc   = 8'h00;
                    if (m_name || m_wifi || m_ip || m_ble) begin
                        n_seen = 1'b1;
                        n_last = r_now;
                    end
                    priority if (m_name) begin
                        n_kind  = slcp_pkg::KIND_NAME;
                        rd_pos  = slcp_pkg::POS_W'(slcp_pkg::START_NAME);
                        n_state = slcp_pkg::S_COPY;
                    end else if (m_wifi) begin
                        n_kind  = slcp_pkg::KIND_WIFI;
                        rd_pos  = slcp_pkg::POS_W'(slcp_pkg::START_WIFI);
                        n_state = slcp_pkg::S_COPY;
                    end else if (m_ip) begin
                        n_kind  = slcp_pkg::KIND_IP;
                        rd_pos  = slcp_pkg::POS_W'(slcp_pkg::START_IP);
                        n_state = slcp_pkg::S_COPY;
                    end else if (m_ble) begin
                        n_kind  = slcp_pkg::KIND_BLE;
                        rd_pos  = slcp_pkg::POS_W'(slcp_pkg::START_BLE);
                        n_state = slcp_pkg::S_BLE;
                    end else begin
                        n_fill  = '0;
                        n_state = slcp_pkg::S_DONE;
                    end
                end
            end

            slcp_pkg::S_COPY: begin
                n_ended = r_ended || (c == 8'h00);
                n_idx   = r_idx + 1'b1;
                unique case (r_kind)
                    slcp_pkg::KIND_NAME: n_name[r_idx[slcp_pkg::NAME_AW-1:0]] = wr_char;
                    slcp_pkg::KIND_WIFI: n_wifi[r_idx[slcp_pkg::WIFI_AW-1:0]] = wr_char;
                    slcp_pkg::KIND_IP:   n_addr[r_idx[slcp_pkg::ADDR_AW-1:0]] = wr_char;
                    default: n_ended = r_ended;
                endcase
                if (r_idx == lim) begin
                    n_fill  = '0;
                    n_state = slcp_pkg::S_DONE;
                end
            end

            slcp_pkg::S_BLE: begin
                if (!r_bdig) begin
                    priority if (is_ws) begin
                        n_bdig = 1'b0;
                    end else if ((c == slcp_pkg::CH_MINUS) || (c == slcp_pkg::CH_PLUS)) begin
                        n_neg  = (c == slcp_pkg::CH_MINUS);
                        n_bdig = 1'b1;
                    end else if (is_dig) begin
                        n_acc  = digit;
                        n_bdig = 1'b1;
                    end else begin
                        n_ble   = r_neg ? (8'h00 - r_acc) : r_acc;
                        n_fill  = '0;
                        n_state = slcp_pkg::S_DONE;
                    end
                end else if (is_dig) begin
                    n_acc = acc10 + digit;
                end else begin
                    n_ble   = r_neg ? (8'h00 - r_acc) : r_acc;
                    n_fill  = '0;
                    n_state = slcp_pkg::S_DONE;
                end
            end

            slcp_pkg::S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_ov        = 1'b1;
                    n_o_applied = (r_kind != slcp_pkg::KIND_NONE);
                    n_o_kind    = r_kind;
                    n_o_disc    = r_disc;
                    n_o_tc      = r_tc;
                    n_o_ble     = r_ble;
                    n_o_seen    = r_seen;
                    n_o_active  = r_seen && (elapsed < r_timeout);
                    n_state     = slcp_pkg::S_IDLE;
                end
            end

            default: n_state = slcp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= slcp_pkg::S_IDLE;
            r_kind    <= slcp_pkg::KIND_NONE;
            r_fill    <= '0;
            r_qpos    <= '0;
            r_idx     <= '0;
            r_ended   <= 1'b0;
            r_m_name  <= 1'b0;
            r_m_wifi  <= 1'b0;
            r_m_ip    <= 1'b0;
            r_m_ble   <= 1'b0;
            r_neg     <= 1'b0;
            r_bdig    <= 1'b0;
            r_acc     <= 8'h00;
            r_ble     <= 8'h00;
            r_seen    <= 1'b0;
            r_last    <= 32'd0;
            r_disc    <= 1'b0;
            r_ov      <= 1'b0;
            r_timeout <= slcp_pkg::TIMEOUT_RESET;
            for (int i = 0; i < slcp_pkg::NAME_LEN; i++) r_name[i] <= 8'h00;
            for (int i = 0; i < slcp_pkg::WIFI_LEN; i++) r_wifi[i] <= 8'h00;
            for (int i = 0; i < slcp_pkg::ADDR_LEN; i++) r_addr[i] <= 8'h00;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_fill   <= n_fill;
            r_qpos   <= rd_pos;
            r_idx    <= n_idx;
            r_ended  <= n_ended;
            r_m_name <= n_m_name;
            r_m_wifi <= n_m_wifi;
            r_m_ip   <= n_m_ip;
            r_m_ble  <= n_m_ble;
            r_neg    <= n_neg;
            r_bdig   <= n_bdig;
            r_acc    <= n_acc;
            r_ble    <= n_ble;
            r_seen   <= n_seen;
            r_last   <= n_last;
            r_disc   <= n_disc;
            r_ov     <= n_ov;
            r_name   <= n_name;
            r_wifi   <= n_wifi;
            r_addr   <= n_addr;
            if (cfg_write && (paddr[2] == slcp_pkg::REG_TIMEOUT)) begin
                r_timeout <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_tc        <= n_tc;
        r_o_applied <= n_o_applied;
        r_o_kind    <= n_o_kind;
        r_o_disc    <= n_o_disc;
        r_o_tc      <= n_o_tc;
        r_o_ble     <= n_o_ble;
        r_o_seen    <= n_o_seen;
        r_o_active  <= n_o_active;
    end

    assign o_in_ready       = (r_state == slcp_pkg::S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_line_applied   = r_o_applied;
    assign o_command_kind   = r_o_kind;
    assign o_line_discarded = r_o_disc;
    assign o_text_char      = r_o_tc;
    assign o_ble_level      = r_o_ble;
    assign o_link_seen      = r_o_seen;
    assign o_link_active    = r_o_active;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= slcp_pkg::FILL_W'(slcp_pkg::STORE_DEPTH))
        else $error("Line fill exceeds the buffer size.");

    a_applied_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_applied == (r_o_kind != slcp_pkg::KIND_NONE)))
        else $error("Applied flag disagrees with the command kind.");

    a_applied_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_o_applied && r_o_disc))
        else $error("A result is both applied and discarded.");

    a_seen_on_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == slcp_pkg::S_DONE) && (r_kind != slcp_pkg::KIND_NONE)) |-> r_seen)
        else $error("An applied line left the seen flag clear.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("A new request was taken while one is in progress.");

endmodule

[dv/tb_status_line_command_parser.sv]
`timescale 1ns / 1ps

module tb_status_line_command_parser;
    import slcp_pkg::*;

    localparam logic [7:0] HASH_CHAR    = 8'h23;
    localparam logic [2:0] TIMEOUT_ADDR = 3'(4 * int'(REG_TIMEOUT));
    localparam int         IDLE_GUARD   = 60;
    localparam int         HOLD_CYCLES  = 300;

    typedef struct {
        logic       applied;
        t_kind      kind;
        logic       discarded;
        logic [7:0] text_char;
        logic [7:0] ble;
        logic       seen;
        logic       active;
    } status_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_opcode;
    logic [7:0]  i_rx_byte;
    logic [1:0]  i_text_select;
    logic [4:0]  i_char_index;
    logic [31:0] i_now_ms;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_line_applied;
    logic [2:0]  o_command_kind;
    logic        o_line_discarded;
    logic [7:0]  o_text_char;
    logic [7:0]  o_ble_level;
    logic        o_link_seen;
    logic        o_link_active;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    status_line_command_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_rx_byte        (i_rx_byte),
        .i_text_select    (i_text_select),
        .i_char_index     (i_char_index),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_line_applied   (o_line_applied),
        .o_command_kind   (o_command_kind),
        .o_line_discarded (o_line_discarded),
        .o_text_char      (o_text_char),
        .o_ble_level      (o_ble_level),
        .o_link_seen      (o_link_seen),
        .o_link_active    (o_link_active),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Shadow copy of the parser state.
    logic [7:0]  line_buf [0:STORE_DEPTH-1];
    int unsigned line_len;
    logic [7:0]  name_mem [0:NAME_LEN-1];
    logic [7:0]  wifi_mem [0:WIFI_LEN-1];
    logic [7:0]  addr_mem [0:ADDR_LEN-1];
    logic [7:0]  ble_q;
    logic [31:0] last_rx_ms;
    logic        seen_q;
    logic [31:0] timeout_q;

    status_result_t pending_results[$];
    logic [31:0]    ms_clock;
    bit             source_steady;
    bit             sink_steady;
    bit             sink_hold_request;
    int             mismatches;
    int             requests_sent;
    int             results_checked;
    int             lines_applied;
    int             lines_discarded;
    int             text_reads;
    int             timeout_settings;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results still pending.", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] line_char(int unsigned p);
        return (p < line_len) ? line_buf[p] : 8'h00;
    endfunction

    function automatic bit line_starts_with(logic [47:0] pfx, int n);
        for (int i = 0; i < n; i++) begin
            if (line_char(i) != pfx[8*(n-1-i) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void copy_value(t_kind kind, int unsigned size, int unsigned from);
        logic [7:0] c;
        bit         ended;
        ended = 1'b0;
        for (int unsigned i = 0; i < size; i++) begin
            c = 8'h00;
            if (i + 1 < size && !ended) begin
                c = line_char(from + i);
                if (c == 8'h00) ended = 1'b1;
            end
            case (kind)
                KIND_NAME: name_mem[i] = c;
                KIND_WIFI: wifi_mem[i] = c;
                default:   addr_mem[i] = c;
            endcase
        end
    endfunction

    function automatic t_kind apply_line();
        logic [7:0]  c;
        logic [7:0]  acc;
        bit          neg;
        int unsigned p;
        if (line_starts_with(PFX_NAME, 6)) begin
            copy_value(KIND_NAME, NAME_LEN, START_NAME);
            return KIND_NAME;
        end
        if (line_starts_with(PFX_WIFI, 6)) begin
            copy_value(KIND_WIFI, WIFI_LEN, START_WIFI);
            return KIND_WIFI;
        end
        if (line_starts_with({16'h0, PFX_IP}, 4)) begin
            copy_value(KIND_IP, ADDR_LEN, START_IP);
            return KIND_IP;
        end
        if (line_starts_with({8'h0, PFX_BLE}, 5)) begin
            // Decimal parse with optional blanks and sign, kept modulo 256.
            p = START_BLE;
            acc = 8'h00;
            neg = 1'b0;
            c = line_char(p);
            while (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
                p++;
                c = line_char(p);
            end
            if (c == CH_MINUS || c == CH_PLUS) begin
                neg = (c == CH_MINUS);
                p++;
                c = line_char(p);
            end
            while (c >= CH_ZERO && c <= CH_NINE) begin
                acc = acc * 8'd10 + (c - CH_ZERO);
                p++;
                c = line_char(p);
            end
            ble_q = neg ? 8'h00 - acc : acc;
            return KIND_BLE;
        end
        return KIND_NONE;
    endfunction

    function automatic status_result_t predict_status(logic op, logic [7:0] rx,
                                                      logic [1:0] sel, logic [4:0] idx,
                                                      logic [31:0] now);
        status_result_t r;
        r.applied   = 1'b0;
        r.kind      = KIND_NONE;
        r.discarded = 1'b0;
        r.text_char = 8'h00;
        if (op == OP_READ) begin
            case (sel)
                SEL_NAME: if (idx < NAME_LEN) r.text_char = name_mem[idx];
                SEL_WIFI: if (idx < WIFI_LEN) r.text_char = wifi_mem[idx];
                SEL_ADDR: if (idx < ADDR_LEN) r.text_char = addr_mem[idx];
                default:  r.text_char = 8'h00;
            endcase
        end else if (rx == CH_LF || rx == CH_CR) begin
            if (line_len != 0) begin
                if (line_buf[0] == HASH_CHAR) r.kind = apply_line();
                line_len = 0;
                if (r.kind != KIND_NONE) begin
                    r.applied  = 1'b1;
                    seen_q     = 1'b1;
                    last_rx_ms = now;
                end
            end
        end else if (line_len < STORE_DEPTH) begin
            line_buf[line_len] = rx;
            line_len++;
        end else begin
            line_len    = 0;
            r.discarded = 1'b1;
        end
        r.ble    = ble_q;
        r.seen   = seen_q;
        r.active = seen_q && ((now - last_rx_ms) < timeout_q);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        status_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result arrived with none expected", $time);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("line_applied", want.applied, o_line_applied);
                check_field("command_kind", want.kind, o_command_kind);
                check_field("line_discarded", want.discarded, o_line_discarded);
                check_field("text_char", want.text_char, o_text_char);
                check_field("ble_level", want.ble, o_ble_level);
                check_field("link_seen", want.seen, o_link_seen);
                check_field("link_active", want.active, o_link_active);
                results_checked++;
            end
        end
    end

    // Result side: short random stalls, plus one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_request) begin
                sink_hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic op, input logic [7:0] rx,
                                input logic [1:0] sel, input logic [4:0] idx);
        status_result_t exp;
        if (!source_steady && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        // Mostly small steps, with jumps and hits right at the timeout edge.
        case ($urandom_range(0, 19))
            0:       ms_clock = $urandom;
            1:       ms_clock = last_rx_ms + timeout_q - $urandom_range(0, 1);
            default: ms_clock = ms_clock + $urandom_range(0, 300);
        endcase
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_rx_byte     <= rx;
        i_text_select <= sel;
        i_char_index  <= idx;
        i_now_ms      <= ms_clock;
        do @(posedge i_clk); while (!o_in_ready);
        exp = predict_status(op, rx, sel, idx, ms_clock);
        pending_results.push_back(exp);
        requests_sent++;
        if (exp.applied) lines_applied++;
        if (exp.discarded) lines_discarded++;
        if (op == OP_READ) text_reads++;
    endtask

    task automatic send_char(input logic [7:0] b);
        send_request(OP_RECEIVE, b, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
    endtask

    task automatic read_char(input logic [1:0] sel, input logic [4:0] idx);
        send_request(OP_READ, 8'($urandom_range(0, 255)), sel, idx);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    function automatic string random_prefix();
        case ($urandom_range(0, 3))
            0:       return "#NAME ";
            1:       return "#WIFI ";
            2:       return "#IP ";
            default: return "#BLE ";
        endcase
    endfunction

    task automatic send_random_line();
        logic [7:0] line_q[$];
        string      pfx;
        int         pick;
        int         n;
        pick = $urandom_range(0, 11);
        case (pick)
            0, 1:    pfx = "#NAME ";
            2, 3:    pfx = "#WIFI ";
            4:       pfx = "#IP ";
            5, 6:    pfx = "#BLE ";
            7: begin
                pfx = random_prefix();
                pfx.putc($urandom_range(0, pfx.len() - 1), 8'($urandom_range(8'h21, 8'h7e)));
            end
            9:       pfx = random_prefix();
            default: pfx = "";
        endcase
        for (int i = 0; i < pfx.len(); i++) line_q.push_back(pfx[i]);
        if (pick == 5 || pick == 6) begin
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(0, 3))
                    0:       line_q.push_back(CH_SPACE);
                    1:       line_q.push_back(CH_TAB);
                    2:       line_q.push_back(CH_VT);
                    default: line_q.push_back(CH_FF);
                endcase
            end
            case ($urandom_range(0, 2))
                0:       line_q.push_back(CH_MINUS);
                1:       line_q.push_back(CH_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(0, 5)) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0) line_q.push_back(plain_byte());
        end else if (pick == 8) begin
            repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
        end else if (pick == 9) begin
            repeat ($urandom_range(47, 60)) line_q.push_back(plain_byte());
        end else if (pick >= 10) begin
            repeat ($urandom_range(1, 4))
                read_char(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
            return;
        end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(26, 44) : $urandom_range(0, 20);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0) line_q.push_back(plain_byte());
                else line_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
            end
        end
        foreach (line_q[i]) send_char(line_q[i]);
        if ($urandom_range(0, 1) == 0) send_char(CH_LF);
        else send_char(CH_CR);
        if ($urandom_range(0, 4) == 0) send_char(CH_LF);
    endtask

    task automatic run_random_lines(input int count);
        int target;
        target = requests_sent + count;
        while (requests_sent < target) send_random_line();
    endtask

    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    task automatic set_link_timeout(input logic [31:0] value);
        wait_for_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        timeout_q = value;
        timeout_settings++;
    endtask

    task automatic test_directed_cases();
        read_char(SEL_NAME, 5'd0);
        send_text("#BLE -7");
        send_char(CH_CR);
        send_char(CH_LF);
        send_text("#IP 1");
        send_char(8'h00);
        send_char("x");
        send_char(CH_LF);
        read_char(SEL_ADDR, 5'd0);
        read_char(SEL_ADDR, 5'd31);
        read_char(2'd3, 5'd31);
        send_char(8'hFF);
        send_char(CH_LF);
        send_char("?");
        send_char(CH_CR);
    endtask

    task automatic test_timeout_extremes();
        set_link_timeout(32'd1);
        run_random_lines(150);
        set_link_timeout(32'hFFFF_FFFF);
        run_random_lines(150);
    endtask

    task automatic test_output_backpressure();
        set_link_timeout(32'($urandom_range(200, 4000)));
        run_random_lines(40);
        sink_hold_request = 1'b1;
        run_random_lines(110);
    endtask

    task automatic test_sender_pause();
        set_link_timeout(TIMEOUT_RESET);
        repeat (3) begin
            run_random_lines(50);
            wait_for_idle();
        end
    endtask

    task automatic test_steady_stream();
        source_steady = 1'b1;
        sink_steady   = 1'b1;
        run_random_lines(120);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_RECEIVE;
        i_rx_byte     = 8'h00;
        i_text_select = SEL_NAME;
        i_char_index  = 5'd0;
        i_now_ms      = 32'd0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        for (int i = 0; i < NAME_LEN; i++) name_mem[i] = 8'h00;
        for (int i = 0; i < WIFI_LEN; i++) wifi_mem[i] = 8'h00;
        for (int i = 0; i < ADDR_LEN; i++) addr_mem[i] = 8'h00;
        line_len   = 0;
        ble_q      = 8'h00;
        last_rx_ms = 32'd0;
        seen_q     = 1'b0;
        timeout_q  = TIMEOUT_RESET;
        ms_clock   = 32'd0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_timeout_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_steady_stream();
        wait_for_idle();

        $display("Sent %0d requests under %0d timeout settings; checked %0d results.",
                 requests_sent, timeout_settings, results_checked);
        $display("Lines applied: %0d, overlong lines dropped: %0d, text reads: %0d.",
                 lines_applied, lines_discarded, text_reads);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
